>>> design/zrr_pkg.sv
`timescale 1ns / 1ps
package zrr_pkg;

    // Field widths of the byte stream and the row register.
    localparam int CHAR_W = 8;
    localparam int CFG_W  = 8;

    // Counts run from 0 to the largest capacity (64) inclusive.
    localparam int CNT_W  = 7;
    // Periods and steps reach 2 * (64 - 1).
    localparam int STEP_W = 8;
    // Position plus step before the compare against the length.
    localparam int SUM_W  = 9;

    localparam int             DEF_MAX_LEN = 64;
    localparam logic [CFG_W-1:0] ROWS_RESET = 8'd3;

    // One emission job handed from the front end to the back end.
    typedef struct packed {
        logic              bank;
        logic [CNT_W-1:0]  len;
        logic [CNT_W-1:0]  rows;
        logic [STEP_W-1:0] period;
        logic              ovf;
    } job_t;

    // Fill state of the job queue.
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

>>> design/zrr_ram.sv
`timescale 1ns / 1ps
module zrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/zrr_front.sv
`timescale 1ns / 1ps
module zrr_front #(
    parameter int MAX_LEN = zrr_pkg::DEF_MAX_LEN
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [zrr_pkg::CHAR_W-1:0]        in_char,
    input  logic                              in_last,
    input  logic                              cfg_we,
    input  logic [zrr_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              job_done,
    output logic                              ram_we,
    output logic [$clog2(MAX_LEN):0]          ram_waddr,
    output logic [zrr_pkg::CHAR_W-1:0]        ram_wdata,
    output logic                              job_push,
    output zrr_pkg::job_t                     job
);
    import zrr_pkg::*;

    localparam int AW = $clog2(MAX_LEN);

    logic [CNT_W-1:0] fill_count_reg, fill_count_next;
    logic             dropped_reg, dropped_next;
    logic             bank_reg, bank_next;
    logic [1:0]       pend_reg, pend_next;
    logic [CFG_W-1:0] rows_cfg_reg;

    logic             accept;
    logic             room;
    logic [CNT_W-1:0] len_now;
    logic [CNT_W-1:0] rows_clamp;

    // A bank is free for writing unless both banks hold strings awaiting output.
    assign busy   = (pend_reg == 2'd2);
    assign accept = start && !busy;
    assign room   = (fill_count_reg < CNT_W'(MAX_LEN));

    assign ram_we    = accept && room;
    assign ram_waddr = {bank_reg, fill_count_reg[AW-1:0]};
    assign ram_wdata = in_char;

    // Classify the finished string: clamp rows, pick pass-through or zigzag.
    always_comb
    begin
        len_now = room ? (fill_count_reg + CNT_W'(1)) : fill_count_reg;
        if (rows_cfg_reg > CFG_W'(len_now))
        begin
            rows_clamp = len_now;
        end
        else
        begin
            rows_clamp = rows_cfg_reg[CNT_W-1:0];
        end
        job.bank = bank_reg;
        job.len  = len_now;
        job.ovf  = dropped_reg || !room;
        if (rows_clamp < CNT_W'(2))
        begin
            // Pass-through is a single row stepping by one.
            job.rows   = CNT_W'(1);
            job.period = STEP_W'(1);
        end
        else
        begin
            job.rows   = rows_clamp;
            job.period = {rows_clamp - CNT_W'(1), 1'b0};
        end
    end

    assign job_push = accept && in_last;

    // Next values of the fill state and the count of outstanding strings.
    always_comb
    begin
        fill_count_next = fill_count_reg;
        dropped_next    = dropped_reg;
        bank_next       = bank_reg;
        if (accept)
        begin
            if (in_last)
            begin
                fill_count_next = '0;
                dropped_next    = 1'b0;
                bank_next       = !bank_reg;
            end
            else if (room)
            begin
                fill_count_next = fill_count_reg + CNT_W'(1);
            end
            else
            begin
                dropped_next = 1'b1;
            end
        end
        pend_next = pend_reg + {1'b0, job_push} - {1'b0, job_done};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
            dropped_reg    <= 1'b0;
            bank_reg       <= 1'b0;
            pend_reg       <= '0;
            rows_cfg_reg   <= ROWS_RESET;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
            dropped_reg    <= dropped_next;
            bank_reg       <= bank_next;
            pend_reg       <= pend_next;
            if (cfg_we)
            begin
                rows_cfg_reg <= cfg_wdata;
            end
        end
    end

    // The outstanding count never passes the number of banks.
    a_pend_max: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("outstanding string count exceeds bank count");

    // A string is never closed while both banks are taken.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (pend_reg < 2'd2))
        else $error("string closed with no free bank");

    // The write index stays inside the bank.
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(MAX_LEN))
        else $error("fill count beyond capacity");

endmodule

>>> design/zrr_job_fifo.sv
`timescale 1ns / 1ps
module zrr_job_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  zrr_pkg::job_t    push_job,
    input  logic             pop,
    output zrr_pkg::job_t    head_job,
    output zrr_pkg::q_stat_t stat
);
    import zrr_pkg::*;

    job_t       entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;

    assign head_job   = entry_reg[rptr_reg];
    assign stat.empty = (count_reg == 2'd0);
    assign stat.full  = (count_reg == 2'd2);

    // Two-entry queue, one entry per buffer bank.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_job;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full && !pop))
        else $error("job queue overrun");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("job queue underrun");

endmodule

>>> design/zrr_back.sv
`timescale 1ns / 1ps
module zrr_back #(
    parameter int MAX_LEN = zrr_pkg::DEF_MAX_LEN
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  zrr_pkg::job_t              head_job,
    input  zrr_pkg::q_stat_t           q_stat,
    output logic                       job_pop,
    output logic                       job_done,
    output logic                       ram_re,
    output logic [$clog2(MAX_LEN):0]   ram_raddr,
    output logic                       out_valid,
    output logic                       out_last,
    output logic                       overflow
);
    import zrr_pkg::*;

    localparam int AW = $clog2(MAX_LEN);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t            state_reg;
    logic              bank_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  rows_reg;
    logic [STEP_W-1:0] period_reg;
    logic              ovf_reg;
    logic [CNT_W-1:0]  row_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    logic              out_last_reg;
    logic              out_ovf_reg;

    logic              edge_row;
    logic [STEP_W-1:0] nstep;
    logic [SUM_W-1:0]  sum;
    logic              stay;
    logic [CNT_W-1:0]  row_inc;
    logic              final_read;

    // Walk of the zigzag: step within a row, then move to the next row.
    always_comb
    begin
        edge_row   = (row_reg == '0) || (row_reg == rows_reg - CNT_W'(1));
        nstep      = edge_row ? period_reg : (period_reg - step_reg);
        sum        = SUM_W'(pos_reg) + SUM_W'(nstep);
        stay       = (sum < SUM_W'(len_reg));
        row_inc    = row_reg + CNT_W'(1);
        final_read = !stay && (row_inc == rows_reg);
    end

    assign job_pop   = (state_reg == ST_IDLE) && !q_stat.empty;
    assign ram_re    = (state_reg == ST_RUN);
    assign ram_raddr = {bank_reg, pos_reg[AW-1:0]};
    assign job_done  = ram_re && final_read;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
            bank_reg      <= 1'b0;
            len_reg       <= '0;
            rows_reg      <= '0;
            period_reg    <= '0;
            ovf_reg       <= 1'b0;
            row_reg       <= '0;
            pos_reg       <= '0;
            step_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= ram_re;
            out_last_reg  <= job_done;
            out_ovf_reg   <= ovf_reg;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_pop)
                    begin
                        bank_reg   <= head_job.bank;
                        len_reg    <= head_job.len;
                        rows_reg   <= head_job.rows;
                        period_reg <= head_job.period;
                        ovf_reg    <= head_job.ovf;
                        row_reg    <= '0;
                        pos_reg    <= '0;
                        step_reg   <= '0;
                        state_reg  <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (stay)
                    begin
                        pos_reg  <= sum[CNT_W-1:0];
                        step_reg <= nstep;
                    end
                    else if (final_read)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        row_reg  <= row_inc;
                        pos_reg  <= row_inc;
                        step_reg <= {row_inc, 1'b0};
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign overflow  = out_ovf_reg;

    // Reads stay inside the stored string.
    a_pos_in_len: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (pos_reg < len_reg))
        else $error("read beyond stored string");

    a_row_in_rows: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (row_reg < rows_reg))
        else $error("row index beyond row count");

    // The closing byte of an emission is followed by a gap before the next one.
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last |=> !out_valid)
        else $error("emission not separated after its final byte");

endmodule

>>> design/zigzag_rail_reorder_top.sv
`timescale 1ns / 1ps
// Once the byte marked last is accepted with the back end idle, its job passes the
// job queue and the registered RAM read; reordered bytes then follow one per cycle.
// Bytes are loaded and emitted on separate ports; two string banks let the next string
// load while the previous one is read out of the RAM port.
// busy is high while both banks hold strings not yet fully read.
// Reset is asynchronous active low; results are strobed and cannot be stalled.
module zigzag_rail_reorder_top #(
    parameter int MAX_LEN = zrr_pkg::DEF_MAX_LEN
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [zrr_pkg::CHAR_W-1:0] in_char,
    input  logic                       in_last,
    input  logic                       cfg_we,
    input  logic [zrr_pkg::CFG_W-1:0]  cfg_wdata,
    output logic                       out_valid,
    output logic [zrr_pkg::CHAR_W-1:0] out_char,
    output logic                       out_last,
    output logic                       overflow
);
    import zrr_pkg::*;

    localparam int AW        = $clog2(MAX_LEN);
    localparam int RAM_DEPTH = 2 * (2 ** AW);

    logic          ram_we;
    logic [AW:0]   ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic          ram_re;
    logic [AW:0]   ram_raddr;
    logic          job_push;
    logic          job_pop;
    logic          job_done;
    job_t          push_job;
    job_t          head_job;
    q_stat_t       q_stat;

    // Two banks of string storage.
    zrr_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (out_char)
    );

    // Front end: loads bytes and closes strings into jobs.
    zrr_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_char   (in_char),
        .in_last   (in_last),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .job_done  (job_done),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .job_push  (job_push),
        .job       (push_job)
    );

    // Queue of closed strings.
    zrr_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    // Back end: reads each string out in zigzag order.
    zrr_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .q_stat    (q_stat),
        .job_pop   (job_pop),
        .job_done  (job_done),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .out_valid (out_valid),
        .out_last  (out_last),
        .overflow  (overflow)
    );

endmodule

>>> tb/sv/zigzag_rail_reorder_top_test.sv
`timescale 1ns / 1ps
module zigzag_rail_reorder_top_test;
    import zrr_pkg::*;

    localparam int MAX_LEN     = DEF_MAX_LEN;
    // Cycles without any accepted transaction before the run is abandoned.
    localparam int QUIET_LIMIT = 1000;
    // Settling time after the last expected byte before the block counts as idle.
    localparam int DRAIN_CYCLES = 12;
    // Random short strings stop once this many bytes have been sent.
    localparam int RANDOM_BYTES = 30;

    // One reordered output byte as seen on the result ports.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              ovf;
    } rail_byte_t;

    // One row of the directed stimulus table.
    typedef struct packed {
        logic              set_rows;
        logic [CFG_W-1:0]  rows;
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              typed;
        rail_byte_t        want;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [CHAR_W-1:0] in_char;
    logic              in_last;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              out_valid;
    logic [CHAR_W-1:0] out_char;
    logic              out_last;
    logic              overflow;

    // Expectation typed into the table, travelling with the transaction.
    logic              row_typed;
    rail_byte_t        row_want;

    // Predictor state: string buffer, fill level, drop flag and row register.
    logic [CHAR_W-1:0] model_buf [MAX_LEN];
    int unsigned       model_fill;
    logic              model_dropped;
    logic [CFG_W-1:0]  model_rows;

    rail_byte_t        zigzag_out [$];
    rail_byte_t        rail_expect [$];
    plan_row_t         plan [$];

    int                fail_count = 0;
    int                random_items = 0;
    int                burst_left = 0;
    bit                calm_phase = 1'b0;

    zigzag_rail_reorder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .in_char   (in_char),
        .in_last   (in_last),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_char  (out_char),
        .out_last  (out_last),
        .overflow  (overflow)
    );

    // Free-running 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Store one byte and, on the last byte, produce the rail fence order.
    function automatic void zigzag_accept(input logic [CHAR_W-1:0] ch, input logic lastb);
        int unsigned len;
        int unsigned rows;
        int unsigned period;
        int unsigned pos;
        int unsigned stride;
        int unsigned r;
        rail_byte_t  rb;
        if (model_fill < MAX_LEN)
        begin
            model_buf[model_fill] = ch;
            model_fill++;
        end
        else
        begin
            model_dropped = 1'b1;
        end
        if (lastb !== 1'b1)
            return;
        len = model_fill;
        rows = (model_rows > len) ? len : model_rows;
        rb.last = 1'b0;
        rb.ovf = model_dropped;
        if (rows < 2)
        begin
            // Too few rows: the string goes out unchanged.
            for (pos = 0; pos < len; pos++)
            begin
                rb.ch = model_buf[pos];
                zigzag_out.push_back(rb);
            end
        end
        else
        begin
            period = 2 * (rows - 1);
            for (r = 0; r < rows; r++)
            begin
                pos = r;
                stride = (r == 0 || r == rows - 1) ? period : 2 * r;
                while (pos < len)
                begin
                    rb.ch = model_buf[pos];
                    zigzag_out.push_back(rb);
                    // Middle rows alternate between two strides summing to the period.
                    if (r != 0 && r != rows - 1)
                        stride = period - stride;
                    pos += stride;
                end
            end
        end
        if (zigzag_out.size() != 0)
        begin
            rb = zigzag_out.pop_back();
            rb.last = 1'b1;
            zigzag_out.push_back(rb);
        end
        model_fill = 0;
        model_dropped = 1'b0;
    endfunction

    // Check every result, then predict from every accepted transaction.
    always @(posedge clk)
    begin
        rail_byte_t want;
        if (rst_n === 1'b1)
        begin
            if (cfg_we === 1'b1)
                model_rows = cfg_wdata;
            if (out_valid === 1'b1)
            begin
                if (rail_expect.size() == 0)
                begin
                    $error("unexpected result: out_char=%02h out_last=%0b overflow=%0b",
                           out_char, out_last, overflow);
                    fail_count++;
                end
                else
                begin
                    want = rail_expect.pop_front();
                    if (out_char !== want.ch)
                    begin
                        $error("out_char: expected %02h, actual %02h", want.ch, out_char);
                        fail_count++;
                    end
                    if (out_last !== want.last)
                    begin
                        $error("out_last: expected %0b, actual %0b", want.last, out_last);
                        fail_count++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $error("overflow: expected %0b, actual %0b", want.ovf, overflow);
                        fail_count++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                zigzag_accept(in_char, in_last);
                if (row_typed === 1'b1)
                begin
                    rail_expect.push_back(row_want);
                end
                else
                begin
                    foreach (zigzag_out[i])
                        rail_expect.push_back(zigzag_out[i]);
                end
                zigzag_out.delete();
            end
        end
    end

    // Watchdog on cycles in which no transaction moves on either side.
    always @(posedge clk)
    begin
        int quiet_cycles;
        if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one byte and hold it until the block takes it.
    task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic lastb,
                             input logic typed, input rail_byte_t want);
        start <= 1'b1;
        in_char <= ch;
        in_last <= lastb;
        row_typed <= typed;
        row_want <= want;
        do
            @(posedge clk);
        while (!(start === 1'b1 && busy === 1'b0));
    endtask

    // Sender works in bursts with random gaps between them.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (!calm_phase && $urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 9);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Hold the sender off until every expected byte has come out.
    // The wait starts on a clock edge so that the checker has queued the final transaction.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (rail_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Row register writes happen only with the block idle.
    task automatic write_rows(input logic [CFG_W-1:0] rows);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= rows;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic plan_row(input logic set_rows, input logic [CFG_W-1:0] rows,
                            input logic [CHAR_W-1:0] ch, input logic lastb,
                            input logic typed, input logic [CHAR_W-1:0] want_ch);
        plan_row_t p;
        p.set_rows = set_rows;
        p.rows = rows;
        p.ch = ch;
        p.last = lastb;
        p.typed = typed;
        p.want.ch = want_ch;
        p.want.last = 1'b1;
        p.want.ovf = 1'b0;
        plan.push_back(p);
    endtask

    // One string of random content, ending with the byte marked last.
    task automatic send_random_string(input int unsigned len);
        logic [CHAR_W-1:0] ch;
        rail_byte_t        none;
        int unsigned       i;
        none = '0;
        for (i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 7))
                0: ch = 8'h00;
                1: ch = 8'hFF;
                default: ch = CHAR_W'($urandom_range(0, 255));
            endcase
            pace_sender();
            send_byte(ch, i == len - 1, 1'b0, none);
            random_items++;
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_rows();
        case ($urandom_range(0, 6))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd255;
            3: return CFG_W'($urandom_range(0, 255));
            default: return CFG_W'($urandom_range(2, 8));
        endcase
    endfunction

    initial
    begin
        int strings_left;
        int unsigned len;
        rst_n = 1'b0;
        start = 1'b0;
        in_char = '0;
        in_last = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        row_typed = 1'b0;
        row_want = '0;
        foreach (model_buf[i])
            model_buf[i] = '0;
        model_fill = 0;
        model_dropped = 1'b0;
        model_rows = ROWS_RESET;

        // Single-byte strings: rows clamp to one, the byte comes straight back.
        plan_row(1'b0, 8'd0, 8'h00, 1'b1, 1'b1, 8'h00);
        plan_row(1'b0, 8'd0, 8'hFF, 1'b1, 1'b1, 8'hFF);
        // Reset row count of three on a five-byte string.
        plan_row(1'b0, 8'd0, 8'h41, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h42, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h43, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h44, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h45, 1'b1, 1'b0, 8'h00);
        // Zero rows: pass-through.
        plan_row(1'b1, 8'd0, 8'h78, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h79, 1'b1, 1'b0, 8'h00);
        // Largest row count, clamped to the string length.
        plan_row(1'b1, 8'd255, 8'h70, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h71, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h72, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h73, 1'b1, 1'b0, 8'h00);
        // Two rows: even positions, then odd ones.
        plan_row(1'b1, 8'd2, 8'hA5, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h5A, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h00, 1'b1, 1'b0, 8'h00);
        // One row: pass-through.
        plan_row(1'b1, 8'd1, 8'h0F, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'hF0, 1'b1, 1'b0, 8'h00);
        // Four rows: two middle rows, each of which reads two bytes of the string.
        plan_row(1'b1, 8'd4, 8'h30, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h31, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h32, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h33, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h34, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h35, 1'b0, 1'b0, 8'h00);
        plan_row(1'b0, 8'd0, 8'h36, 1'b1, 1'b0, 8'h00);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, with no sender gaps.
        calm_phase = 1'b1;
        foreach (plan[i])
        begin
            if (plan[i].set_rows)
                write_rows(plan[i].rows);
            send_byte(plan[i].ch, plan[i].last, plan[i].typed, plan[i].want);
        end

        // A string that fills the buffer exactly and then overflows it,
        // so that the byte marked last is itself dropped.
        calm_phase = 1'b0;
        write_rows(CFG_W'($urandom_range(2, 12)));
        send_random_string(MAX_LEN + 2);

        // Random phases: a row setting, then a few strings of random length.
        while (random_items < MAX_LEN + 2 + RANDOM_BYTES)
        begin
            write_rows(pick_rows());
            calm_phase = ($urandom_range(0, 4) == 0);
            strings_left = $urandom_range(1, 4);
            while (strings_left > 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(13, 40);
                else
                    len = $urandom_range(1, 12);
                send_random_string(len);
                if ($urandom_range(0, 5) == 0)
                    wait_idle();
                strings_left--;
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
